/* hw/rtl/windowed_distinct_subarray_counter_assert.svh */
// Assertion macros for the windowed distinct subarray counter
`ifndef WINDOWED_DISTINCT_SUBARRAY_COUNTER_ASSERT_SVH
`define WINDOWED_DISTINCT_SUBARRAY_COUNTER_ASSERT_SVH
// implication checked every clock, disabled in reset
`define WDSC_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("%m: label failed");
// next-cycle implication
`define WDSC_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("%m: label failed");
`endif

/* hw/rtl/wdsc_pkg.sv */
// Shared types and constants for the windowed distinct subarray counter
package wdsc_pkg;
    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 24;
    localparam int unsigned KW     = 5;
    localparam logic [CountW-1:0] CountMax = '1;

    typedef struct packed {
        logic clear;   // clear run state
        logic write;   // store value, bump right index
        logic add;     // add value to table
        logic remove;  // remove value at left index
        logic rd_left; // start read of left entry
        logic accum;   // add window length to total
        logic ovf;     // set sticky overflow
    } wdsc_cmd_t;

    typedef struct packed {
        logic full;     // right index reached the store depth
        logic too_many; // distinct count above k and window not empty
    } wdsc_sts_t;
endpackage

/* hw/rtl/wdsc_datapath.sv */
// Datapath: value store, key/count table, window pointers and total
module wdsc_datapath #(
    parameter int unsigned MAX_LEN      = 4096,
    parameter int unsigned MAX_DISTINCT = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [wdsc_pkg::ValueW-1:0] value,
    input  logic [wdsc_pkg::KW-1:0]    k_eff,
    input  wdsc_pkg::wdsc_cmd_t        cmd,
    output wdsc_pkg::wdsc_sts_t        sts,
    output logic [wdsc_pkg::CountW-1:0] total,
    output logic                       ovf
);
    import wdsc_pkg::*;

    localparam int unsigned AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned PW   = $clog2(MAX_LEN + 1);
    localparam int unsigned TS   = MAX_DISTINCT + 1;
    localparam int unsigned DW   = $clog2(TS + 1);
    localparam int unsigned CW   = PW;

    logic [ValueW-1:0] store_mem [MAX_LEN];
    logic [ValueW-1:0] rd_data_reg;

    logic [ValueW-1:0] keys_reg [TS];
    logic [CW-1:0]     counts_reg [TS];
    logic [TS-1:0]     valid_reg;
    logic [DW-1:0]     distinct_reg;
    logic [PW-1:0]     left_reg, right_reg;
    logic [CountW-1:0] total_reg;
    logic              ovf_reg;

    logic [ValueW-1:0] key;
    logic [TS-1:0]     hit;
    logic [TS-1:0]     free_oh;
    logic              any_hit;
    logic [PW-1:0]     win_len;
    logic [CountW:0]   sum;

    assign key = cmd.remove ? rd_data_reg : value;

    always_comb begin
        any_hit = 1'b0;
        for (int i = 0; i < TS; i++) begin
            hit[i] = valid_reg[i] && (keys_reg[i] == key);
            any_hit |= hit[i];
        end
        free_oh = ~valid_reg & (valid_reg + 1'b1);
    end

    assign win_len = right_reg - left_reg;
    assign sum = {1'b0, total_reg} + (CountW+1)'(win_len);

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            store_mem[right_reg[AW-1:0]] <= value;
        end
        if (cmd.rd_left) begin
            rd_data_reg <= store_mem[left_reg[AW-1:0]];
        end
        for (int i = 0; i < TS; i++) begin
            if (cmd.add && !any_hit && free_oh[i]) begin
                keys_reg[i] <= value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            valid_reg    <= '0;
            distinct_reg <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            for (int i = 0; i < TS; i++) counts_reg[i] <= '0;
        end else begin
            if (cmd.write) right_reg <= right_reg + 1'b1;
            if (cmd.ovf) ovf_reg <= 1'b1;
            if (cmd.add) begin
                if (any_hit) begin
                    for (int i = 0; i < TS; i++)
                        if (hit[i]) counts_reg[i] <= counts_reg[i] + 1'b1;
                end else if (free_oh != '0) begin
                    for (int i = 0; i < TS; i++)
                        if (free_oh[i]) begin
                            counts_reg[i] <= CW'(1);
                            valid_reg[i]  <= 1'b1;
                        end
                    distinct_reg <= distinct_reg + 1'b1;
                end
            end
            if (cmd.remove) begin
                left_reg <= left_reg + 1'b1;
                for (int i = 0; i < TS; i++)
                    if (hit[i]) begin
                        if (counts_reg[i] <= CW'(1)) begin
                            counts_reg[i] <= '0;
                            valid_reg[i]  <= 1'b0;
                        end else begin
                            counts_reg[i] <= counts_reg[i] - 1'b1;
                        end
                    end
                if (any_hit && distinct_reg != '0) begin
                    for (int i = 0; i < TS; i++)
                        if (hit[i] && counts_reg[i] <= CW'(1))
                            distinct_reg <= distinct_reg - 1'b1;
                end
            end
            if (cmd.accum) total_reg <= sum[CountW] ? CountMax : sum[CountW-1:0];
        end
    end

    assign sts.full     = (right_reg >= PW'(MAX_LEN));
    assign sts.too_many = (32'(distinct_reg) > 32'(k_eff)) && (left_reg < right_reg);
    assign total        = total_reg;
    assign ovf          = ovf_reg;
endmodule

/* hw/rtl/wdsc_ctrl.sv */
// Controller: sequences insert, shrink and accumulate for each beat, or flags overflow when the store is full
module wdsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                in_last,
    input  logic                out_free,
    input  wdsc_pkg::wdsc_sts_t sts,
    output wdsc_pkg::wdsc_cmd_t cmd,
    output logic                busy,
    output logic                emit,
    output logic                emit_last
);
    import wdsc_pkg::*;

    typedef enum logic [2:0] {IDLE, INS, CHECK, READ, REMOVE, ACC, EMIT} state_t;
    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        emit       = 1'b0;
        unique case (state_reg)
            IDLE: begin
                if (in_fire) begin
                    last_next = in_last;
                    if (sts.full) begin
                        cmd.ovf    = 1'b1;
                        state_next = EMIT;
                    end else begin
                        cmd.write  = 1'b1;
                        cmd.add    = 1'b1;
                        state_next = CHECK;
                    end
                end
            end
            INS:   state_next = CHECK;
            CHECK: state_next = sts.too_many ? READ : ACC;
            READ: begin
                cmd.rd_left = 1'b1;
                state_next  = REMOVE;
            end
            REMOVE: begin
                cmd.remove = 1'b1;
                state_next = CHECK;
            end
            ACC: begin
                cmd.accum  = 1'b1;
                state_next = EMIT;
            end
            EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    cmd.clear  = last_reg;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign busy      = (state_reg != IDLE);
    assign emit_last = last_reg;
endmodule

/* hw/rtl/windowed_distinct_subarray_counter.sv */
// Top level: counts subarrays with at most k distinct values, one result per beat
// Flow: a beat is stored and counted; CHECK, READ and REMOVE drop values from the
// window left side while over k are distinct; then ACC, EMIT. A held result beat
// delays the next emit. Throughput: one beat at a time, input ready again when the
// controller returns to IDLE; each value leaves the window once.
// Reset: aresetn sync active low; clears run state, max_distinct to 1; tlast clears run.
module windowed_distinct_subarray_counter #(
    parameter int unsigned MAX_LEN      = 4096,
    parameter int unsigned MAX_DISTINCT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] running_count, [24] overflow, rest zero
    output logic        m_tlast,   // final_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // max_distinct
);
    import wdsc_pkg::*;

    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_eff;
    wdsc_cmd_t     cmd;
    wdsc_sts_t     sts;
    logic [CountW-1:0] total;
    logic ovf, busy, emit, emit_last, in_fire;
    logic              mv_reg;
    logic [CountW-1:0] mcount_reg;
    logic              movf_reg, mlast_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) k_reg <= KW'(1);
        else if (cfg_valid) k_reg <= cfg_data;
    end

    // saturate k into 1..MAX_DISTINCT
    always_comb begin
        if (k_reg == '0) k_eff = KW'(1);
        else if (32'(k_reg) > MAX_DISTINCT) k_eff = KW'(MAX_DISTINCT);
        else k_eff = k_reg;
    end

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    wdsc_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_fire, .in_last(s_tlast), .out_free(!mv_reg || m_tready),
        .sts, .cmd, .busy, .emit, .emit_last
    );

    wdsc_datapath #(.MAX_LEN(MAX_LEN), .MAX_DISTINCT(MAX_DISTINCT)) u_dp (
        .aclk, .aresetn, .value(s_tdata), .k_eff, .cmd, .sts, .total, .ovf
    );

    // output register: result beat held until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (emit) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
        if (emit) begin
            mcount_reg <= total;
            movf_reg   <= ovf;
            mlast_reg  <= emit_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0, movf_reg, mcount_reg};
    assign m_tlast  = mlast_reg;
endmodule

/* hw/rtl/wdsc_checker.sv */
// Port-level checker for the windowed distinct subarray counter, with bind
`include "windowed_distinct_subarray_counter_assert.svh"
module wdsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    `WDSC_ASSERT_NXT(a_in_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `WDSC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `WDSC_ASSERT_NXT(a_last_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tlast))
    `WDSC_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[31:25] == 7'd0)
    `WDSC_ASSERT_NXT(a_no_emit_soon, aclk, aresetn, s_tvalid && s_tready, !($rose(m_tvalid)))
endmodule

bind windowed_distinct_subarray_counter wdsc_checker u_wdsc_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
